/* sv/pstb_pkg.sv */
// shared types and constants for the periodic soft timer bank
package pstb_pkg;

	localparam int TIMER_COUNT_DEF = 4;
	localparam int ID_W            = 6;
	localparam int CNT_W           = 16;
	localparam int MAX_REPORTS     = 4;
	localparam int RPT_W           = $clog2(MAX_REPORTS + 1);

	typedef enum logic [2:0] {
		OP_START    = 3'd0,
		OP_STOP     = 3'd1,
		OP_TICK_ALL = 3'd2,
		OP_TICK_ONE = 3'd3,
		OP_POLL     = 3'd4
	} op_t;

	// decoded command broadcast to every timer cell
	typedef struct packed {
		logic             start;
		logic             stop;
		logic             tick_all;
		logic             tick_one;
		logic [ID_W-1:0]  timer_id;
		logic [CNT_W-1:0] period;
		logic             notify;
	} pstb_cmd_t;

endpackage

/* sv/pstb_cell.sv */
// one timer cell: holds a timer's state and passes the poll token to its neighbor
module pstb_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pstb_pkg::pstb_cmd_t cmd,
	input  logic                tok_in,
	input  logic                adv,
	output logic                tok,
	output logic                rep
);
	import pstb_pkg::*;

	logic             act_q;
	logic             ren_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] per_q;
	logic             tok_q;
	logic             sel;
	logic             due;
	logic             expire;

	assign sel    = (cmd.timer_id == ID_W'(IDX));
	assign due    = (cnt_q >= per_q);
	assign expire = tok_q && adv && act_q && due;
	assign rep    = tok_q && act_q && due && ren_q;
	assign tok    = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			ren_q <= 1'b0;
			cnt_q <= '0;
			per_q <= '0;
			tok_q <= 1'b0;
		end else begin
			if (adv) begin
				tok_q <= tok_in;
			end
			if (cmd.start && sel) begin
				act_q <= 1'b1;
				ren_q <= cmd.notify;
				per_q <= cmd.period;
			end else if (cmd.stop && sel) begin
				act_q <= 1'b0;
				ren_q <= 1'b0;
			end
			if (cmd.start && sel) begin
				cnt_q <= '0;
			end else if (expire) begin
				cnt_q <= '0;
			end else if ((cmd.tick_all && act_q) || (cmd.tick_one && sel)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

/* sv/periodic_soft_timer_bank.sv */
// top level of the periodic soft timer bank: command decode, timer cell chain, report output
// A bank of TIMER_COUNT periodic timers built as a row of cells, one per timer.
// Start, stop, tick-all and tick-one requests take effect in the cycle they are
// accepted and the block is ready again in the next cycle. A poll request sends a
// token down the cell chain, one cell per cycle while the walk is not held, and
// the block takes no request until the poll ends. Each cell that has expired
// clears its count as the token leaves it, and a reporting cell hands its id to
// a one-deep holding register. A report is released only when the next one is
// found or the walk ends, which is how the final report of a poll gets tlast.
// The walk pauses when a new report is found while one is held and the result
// register is full with m_tready low. At most MAX_REPORTS reports leave one poll;
// further expired timers are cleared silently. Ids at or above TIMER_COUNT are ignored.
module periodic_soft_timer_bank #(
	parameter int TIMER_COUNT = pstb_pkg::TIMER_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request: op [2:0], timer_id [8:3], period [24:9], notify [25], zero fill above
	input  logic [31:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// report: fired_id [5:0], zero fill above
	output logic [7:0]  m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        m_tlast
);
	import pstb_pkg::*;

	// request fields
	logic [2:0]       req_op;
	logic [ID_W-1:0]  req_id;
	logic [CNT_W-1:0] req_period;
	logic             req_notify;
	logic             req_fire;
	logic             poll_start;
	pstb_cmd_t        cmd;

	// token chain
	logic [TIMER_COUNT-1:0] tok;
	logic [TIMER_COUNT-1:0] rep;
	logic [TIMER_COUNT:0]   tok_link;
	logic                   tok_any;
	logic                   adv;

	// report handling
	logic             hit;
	logic [ID_W-1:0]  hit_id;
	logic             push;
	logic             walk_end;
	logic             out_free;
	logic             flush_go;
	logic             pend_q;
	logic [ID_W-1:0]  pend_id_q;
	logic             flush_q;
	logic [RPT_W-1:0] rpt_cnt_q;
	logic             out_valid_q;
	logic [ID_W-1:0]  out_id_q;
	logic             out_last_q;
	logic             busy;

	assign req_op     = s_tdata[2:0];
	assign req_id     = s_tdata[8:3];
	assign req_period = s_tdata[24:9];
	assign req_notify = s_tdata[25];

	// busy while a poll walk or its final report is still in flight
	assign busy     = tok_any || pend_q || flush_q;
	assign s_tready = !busy;
	assign req_fire = s_tvalid && s_tready;

	// opcode decode; unused codes do nothing
	always_comb begin
		cmd          = '0;
		cmd.timer_id = req_id;
		cmd.period   = req_period;
		cmd.notify   = req_notify;
		poll_start   = 1'b0;
		if (req_fire) begin
			unique case (req_op)
				OP_START:    cmd.start    = 1'b1;
				OP_STOP:     cmd.stop     = 1'b1;
				OP_TICK_ALL: cmd.tick_all = 1'b1;
				OP_TICK_ONE: cmd.tick_one = 1'b1;
				OP_POLL:     poll_start   = 1'b1;
				default:     ;
			endcase
		end
	end

	// chain of timer cells, token enters at cell 0
	assign tok_link[0] = poll_start;

	for (genvar g = 0; g < TIMER_COUNT; g++) begin : g_cell
		pstb_cell #(
			.IDX(g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.tok_in (tok_link[g]),
			.adv    (adv),
			.tok    (tok[g]),
			.rep    (rep[g])
		);
		assign tok_link[g+1] = tok[g];
	end

	// the token is one-hot, so the reporting cell id is an or of the token positions
	always_comb begin
		hit_id = '0;
		for (int k = 0; k < TIMER_COUNT; k++) begin
			if (tok[k]) begin
				hit_id = hit_id | ID_W'(k);
			end
		end
	end

	assign tok_any  = |tok;
	assign hit      = (|rep) && (rpt_cnt_q < RPT_W'(MAX_REPORTS));
	assign out_free = !out_valid_q || m_tready;
	// hold the walk when a new report would displace a held one that cannot leave
	assign adv      = !(hit && pend_q && !out_free);
	assign push     = hit && adv;
	assign walk_end = tok[TIMER_COUNT-1] && adv;
	assign flush_go = flush_q && pend_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			pend_id_q   <= '0;
			flush_q     <= 1'b0;
			rpt_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_id_q    <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (poll_start) begin
				rpt_cnt_q <= '0;
			end else if (push) begin
				rpt_cnt_q <= rpt_cnt_q + RPT_W'(1);
			end

			if (walk_end) begin
				flush_q <= 1'b1;
			end else if (flush_q && (!pend_q || flush_go)) begin
				flush_q <= 1'b0;
			end

			// held report: replaced on a new hit, drained at the end of the walk
			if (push) begin
				pend_q    <= 1'b1;
				pend_id_q <= hit_id;
			end else if (flush_go) begin
				pend_q <= 1'b0;
			end

			// result register
			if (push && pend_q) begin
				out_valid_q <= 1'b1;
				out_id_q    <= pend_id_q;
				out_last_q  <= 1'b0;
			end else if (flush_go) begin
				out_valid_q <= 1'b1;
				out_id_q    <= pend_id_q;
				out_last_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(8 - ID_W){1'b0}}, out_id_q};
	assign m_tlast  = out_last_q;

endmodule
